FILE: src/gsg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gsg_pkg: shared definitions of the Gaussian sample generator
// Generator state, its step function, fixed-point constants and link types.
// ============================================================================
package gsg_pkg;

  localparam int SAMPLE_FRAC_BITS_DEF  = 16;
  localparam int UNIFORM_FRAC_BITS_DEF = 32;

  localparam int SAMPLE_W    = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_Z = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_W = 2'd3;

  localparam logic [31:0] SEED_X_RST = 32'd123456789;
  localparam logic [31:0] SEED_Y_RST = 32'd234567891;
  localparam logic [30:0] SEED_Z_RST = 31'd345678912;
  localparam logic [30:0] SEED_W_RST = 31'd456789123;

  localparam logic [31:0] WEYL_STEP = 32'd1411392427;
  localparam logic [31:0] V_SCALE   = 32'd3684067834;
  localparam logic [63:0] V_OFFSET  = 64'd1842033917;
  // ln 2 in Q.26, times four
  localparam logic signed [28:0] LN2_X4 = 29'sd186065280;

  localparam int MAX_TRIES   = 256;
  localparam int TRY_W       = $clog2(MAX_TRIES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Shared divider: 64-bit dividend, 33-bit divisor, 38 quotient bits
  localparam int DIV_DEND_W = 64;
  localparam int DIV_DSR_W  = 33;
  localparam int DIV_QB     = 38;
  localparam int DIV_CNT_W  = $clog2(DIV_QB + 1);

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 20'sd524287;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -20'sd524288;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] z;
    logic [30:0] w;
    logic        c;
  } gen_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic gen_state_t gen_step(input gen_state_t s);
    gen_state_t  n;
    logic [31:0] y;
    logic [31:0] t;
    y   = s.y;
    y   = y ^ (y << 5);
    y   = y ^ (y >> 7);
    y   = y ^ (y << 22);
    t   = {1'b0, s.z} + {1'b0, s.w} + {31'b0, s.c};
    n.y = y;
    n.z = s.w;
    n.c = t[31];
    n.w = t[30:0];
    n.x = s.x + WEYL_STEP;
    return n;
  endfunction

  function automatic logic [31:0] gen_out(input gen_state_t s);
    return s.x + s.y + {1'b0, s.w};
  endfunction

endpackage

FILE: src/gsg_front.sv
`timescale 1ns / 1ps
// ============================================================================
// gsg_front: request intake
// Accepts request items, drops those that ask for nothing and counts the rest
// in a short pending queue that the back end drains.
// ============================================================================
module gsg_front import gsg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic draw_request_i,
  input  logic pop_i,
  output logic pending_o
);

  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;

  assign in_ready_o = (count_q < QCNT_W'(QUEUE_DEPTH));
  // only a set request bit asks for a sample
  assign push       = in_valid_i && in_ready_o && draw_request_i;
  assign pending_o  = (count_q != '0);

  always_comb begin
    count_d = count_q + QCNT_W'(push) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: src/gsg_div.sv
`timescale 1ns / 1ps
// ============================================================================
// gsg_div: shared restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits.
// ============================================================================
module gsg_div import gsg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIV_DEND_W-1:0] dividend_i,
  input  logic [DIV_DSR_W-1:0]  divisor_i,
  output div_status_t           status_o,
  output logic [DIV_QB-1:0]     quotient_o
);

  logic [DIV_DSR_W-1:0]  rem_q;
  logic [DIV_QB-1:0]     low_q;
  logic [DIV_QB-1:0]     quo_q;
  logic [DIV_DSR_W-1:0]  dsr_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  busy_q, done_q;
  logic [DIV_DSR_W:0]    shifted, diff;
  logic                  ge;

  assign shifted = {rem_q, low_q[DIV_QB-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      rem_q  <= {{(DIV_DSR_W-(DIV_DEND_W-DIV_QB)){1'b0}}, dividend_i[DIV_DEND_W-1:DIV_QB]};
      low_q  <= dividend_i[DIV_QB-1:0];
      dsr_q  <= divisor_i;
      cnt_q  <= DIV_CNT_W'(DIV_QB);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DSR_W-1:0] : shifted[DIV_DSR_W-1:0];
      low_q <= {low_q[DIV_QB-2:0], 1'b0};
      quo_q <= {quo_q[DIV_QB-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

FILE: src/gsg_back.sv
`timescale 1ns / 1ps
// ============================================================================
// gsg_back: ratio-of-uniforms engine
// Draws uniform pairs, runs the bound tests and the log test, and holds the
// finished sample in the output register.
// ============================================================================
module gsg_back import gsg_pkg::*; #(
  parameter int SAMPLE_FRAC_BITS  = SAMPLE_FRAC_BITS_DEF,
  parameter int UNIFORM_FRAC_BITS = UNIFORM_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       pending_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  localparam int UFB       = UNIFORM_FRAC_BITS;
  localparam int U30_SR    = (UFB >= 30) ? UFB - 30 : 0;
  localparam int U30_SL    = (UFB < 30) ? 30 - UFB : 0;
  localparam int SAMPLE_SR = 28 - SAMPLE_FRAC_BITS;
  localparam logic [63:0] PART_MASK = (64'd1 << UFB) - 64'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_DRAW, S_VMUL, S_MAG, S_DIVX, S_SQ, S_QA, S_DIVR,
    S_QR, S_LOGI, S_LOG, S_LOGM, S_LOGC, S_NEXT, S_OUT
  } state_e;

  state_e                      state_q;
  gen_state_t                  gen_q;
  logic [TRY_W-1:0]            tries_q;
  logic [32:0]                 uq_q;
  logic                        whole_q;
  logic [31:0]                 part_q;
  logic [63:0]                 prod_q;
  logic                        neg_q;
  logic [30:0]                 u30_q;
  logic [30:0]                 xq_q;
  logic [63:0]                 x2_q, usq_q;
  logic signed [63:0]          qr_q, lnq_q;
  logic [4:0]                  k_q, li_q;
  logic [31:0]                 m_q;
  logic [29:0]                 frac_q;
  logic signed [SAMPLE_W-1:0]  res_q, sample_q;
  logic                        out_valid_q;

  gen_state_t                  g1, g2;
  logic [31:0]                 r1, r2;
  logic [32:0]                 uq_c, u2_c;
  logic [63:0]                 v_c, mag_c, dend_c, lim_c, u30_w, qa_c, sq_c, sh_c;
  logic [61:0]                 x2_c, usq_c;
  logic                        rej_x, acc_qa, far_r, rej_r, ok_log;
  logic [4:0]                  k_c;
  logic [31:0]                 m_c;
  logic signed [37:0]          l2_c;
  logic signed [66:0]          ln_c;
  logic [31:0]                 s_mag;
  logic signed [31:0]          s_sgn;
  logic signed [SAMPLE_W-1:0]  res_c;
  logic                        out_load;
  logic                        div_start;
  logic [DIV_DEND_W-1:0]       div_dend;
  logic [DIV_DSR_W-1:0]        div_dsr;
  div_status_t                 div_stat;
  logic [DIV_QB-1:0]           div_quo;

  gsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_dsr),
    .status_o   (div_stat),
    .quotient_o (div_quo)
  );

  always_comb begin
    // two generator steps per try
    g1     = gen_step(gen_q);
    r1     = gen_out(g1);
    g2     = gen_step(g1);
    r2     = gen_out(g2);
    uq_c   = {1'b0, r1 >> (32 - UFB)} + (33'd1 << (UFB - 23));
    u2_c   = {1'b0, r2 >> (32 - UFB)} + (33'd1 << (UFB - 23));
    // v = scale*u2 - offset in Q1.31
    v_c    = {32'b0, (whole_q ? V_SCALE : 32'd0)} + (prod_q >> UFB) - V_OFFSET;
    mag_c  = v_c[63] ? (~v_c + 64'd1) : v_c;
    dend_c = {32'b0, mag_c[31:0]} << (UFB - 3);
    lim_c  = {31'b0, uq_q} << 31;
    rej_x  = dend_c >= lim_c;           // ratio of eight or more
    u30_w  = ({31'b0, uq_q} >> U30_SR) << U30_SL;
    // full-width squares of the ratio and of u
    x2_c   = xq_q * xq_q;
    usq_c  = u30_q * u30_q;
    // quick accept bound 6 - 8u + 2u^2
    qa_c   = (64'd6 << 56) - ({33'b0, u30_q} << 29) + (usq_q >> 3);
    acc_qa = $signed(x2_q) <= $signed(qa_c);
    far_r  = u30_q > 31'd16777216;      // else 2/u - 2u cannot reject
    rej_r  = (qr_q < (64'sd1 <<< 37)) && ($signed(x2_q) > (qr_q <<< 25));
    k_c    = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (u30_q[i]) k_c = 5'(i);
    end
    m_c    = {1'b0, u30_q} << (5'd30 - k_c);
    sq_c   = m_q * m_q;
    sh_c   = sq_c >> 30;
    l2_c   = (($signed({33'b0, k_q}) - 38'sd30) <<< 30) + $signed({8'b0, frac_q});
    ln_c   = l2_c * LN2_X4;
    ok_log = $signed(x2_q) <= lnq_q;
    // truncate, apply sign, saturate
    s_mag  = {1'b0, xq_q} >> SAMPLE_SR;
    s_sgn  = neg_q ? -$signed(s_mag) : $signed(s_mag);
    if (s_sgn > 32'(OUT_MAX)) res_c = OUT_MAX;
    else if (s_sgn < 32'(OUT_MIN)) res_c = OUT_MIN;
    else res_c = s_sgn[SAMPLE_W-1:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_dend  = dend_c;
    div_dsr   = uq_q;
    if (state_q == S_MAG && !rej_x) begin
      div_start = 1'b1;
    end else if (state_q == S_QA && !acc_qa && far_r) begin
      div_start = 1'b1;
      div_dend  = 64'd1 << 62;
      div_dsr   = {2'b0, u30_q};
    end
  end

  assign pop_o    = (state_q == S_IDLE) && pending_i;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_q       <= '{x: SEED_X_RST, y: SEED_Y_RST, z: SEED_Z_RST, w: SEED_W_RST, c: 1'b0};
      tries_q     <= '0;
      li_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pending_i) begin
            tries_q <= '0;
            state_q <= S_DRAW;
          end
        end
        S_DRAW: begin
          gen_q   <= g2;
          uq_q    <= uq_c;
          whole_q <= u2_c[UFB];
          part_q  <= u2_c[31:0] & PART_MASK[31:0];
          state_q <= S_VMUL;
        end
        S_VMUL: begin
          prod_q  <= V_SCALE * part_q;
          state_q <= S_MAG;
        end
        S_MAG: begin
          neg_q   <= v_c[63];
          u30_q   <= u30_w[30:0];
          state_q <= rej_x ? S_NEXT : S_DIVX;
        end
        S_DIVX: begin
          if (div_stat.done) begin
            xq_q    <= div_quo[30:0];
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          x2_q    <= {2'b0, x2_c};
          usq_q   <= {2'b0, usq_c};
          state_q <= S_QA;
        end
        S_QA: begin
          if (acc_qa) begin
            res_q   <= res_c;
            state_q <= S_OUT;
          end else begin
            state_q <= far_r ? S_DIVR : S_LOGI;
          end
        end
        S_DIVR: begin
          if (div_stat.done) begin
            qr_q    <= $signed({26'b0, div_quo}) - $signed({31'b0, u30_q, 2'b0});
            state_q <= S_QR;
          end
        end
        S_QR: begin
          state_q <= rej_r ? S_NEXT : S_LOGI;
        end
        S_LOGI: begin
          k_q     <= k_c;
          m_q     <= m_c;
          frac_q  <= '0;
          li_q    <= 5'd29;
          state_q <= S_LOG;
        end
        S_LOG: begin
          // square and halve, one fraction bit per cycle
          if (sh_c[31]) begin
            m_q          <= sh_c[32:1];
            frac_q[li_q] <= 1'b1;
          end else begin
            m_q <= sh_c[31:0];
          end
          if (li_q == 5'd0) state_q <= S_LOGM;
          else li_q <= li_q - 5'd1;
        end
        S_LOGM: begin
          lnq_q   <= -ln_c[63:0];
          state_q <= S_LOGC;
        end
        S_LOGC: begin
          if (ok_log) begin
            res_q   <= res_c;
            state_q <= S_OUT;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (tries_q == TRY_W'(MAX_TRIES - 1)) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else begin
            tries_q <= tries_q + 1'b1;
            state_q <= S_DRAW;
          end
        end
        S_OUT: begin
          if (out_load) begin
            sample_q <= res_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // seed writes reload one generator word; carry untouched
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SEED_X: gen_q.x <= cfg_data_i;
          CFG_SEED_Y: gen_q.y <= cfg_data_i;
          CFG_SEED_Z: gen_q.z <= cfg_data_i[30:0];
          CFG_SEED_W: gen_q.w <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_DRAW)
    else $error("pop without starting a draw");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || out_ready_i)) |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVR) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

endmodule

FILE: src/gaussian_sample_generator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// gaussian_sample_generator_core: standard normal sample generator
// Ratio-of-uniforms sampler on a JKISS32 source, Q4.16 saturated output.
// ============================================================================
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid_i, in_ready_o, draw_request_i  | request
//  out     | out_valid_o, out_ready_i, sample_o      | result
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i       | seed write
//
// A try may end at the quick accept bound or go on to the reject bound and the
// log test, which may use the shared divider a second time and run the 30-round
// log loop. About 1.37 tries per item are expected, at most 256.
// Reset loads the fixed seeds and clears the carry, the queue and the output valid flag.
// The front keeps taking items into a four-entry queue while a result waits.
//
module gaussian_sample_generator_core import gsg_pkg::*; #(
  parameter int SAMPLE_FRAC_BITS  = SAMPLE_FRAC_BITS_DEF,
  parameter int UNIFORM_FRAC_BITS = UNIFORM_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       draw_request_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  logic pending, pop;

  // front: take items, drop empty requests, queue the rest
  gsg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .draw_request_i (draw_request_i),
    .pop_i          (pop),
    .pending_o      (pending)
  );

  // back: draw, test and hold the sample
  gsg_back #(
    .SAMPLE_FRAC_BITS  (SAMPLE_FRAC_BITS),
    .UNIFORM_FRAC_BITS (UNIFORM_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_i   (pending),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o)
  );

endmodule

FILE: tb/gaussian_sample_generator_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gaussian_sample_generator_core_tb: self-checking bench of the normal sampler
// Sends draw requests under random idling and seed reloads, predicts every
// sample with an independent ratio-of-uniforms model and checks each result.
// ============================================================================
module gaussian_sample_generator_core_tb;
  import gsg_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam longint LN2_Q26  = 64'sd46516320;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       draw_request_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                       cfg_we_i;
  logic [CFG_INDEX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;

  gaussian_sample_generator_core dut (.*);

  // Shadow copy of the JKISS32 words
  logic [31:0] sh_count;
  logic [31:0] sh_xor;
  logic [30:0] sh_lag_lo;
  logic [30:0] sh_lag_hi;
  logic        sh_carry;

  logic signed [SAMPLE_W-1:0] pending_samples[$];

  bit calm;
  int n_requests, n_zero_requests, n_samples, n_seed_writes, n_errors;

  typedef struct {
    bit                     wr;
    logic [CFG_INDEX_W-1:0] idx;
    logic [31:0]            data;
    bit                     req;
  } stim_row_t;

  stim_row_t directed[$];

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] jkiss_next();
    logic [31:0] y;
    logic [31:0] t;
    y = sh_xor;
    y = y ^ (y << 5);
    y = y ^ (y >> 7);
    y = y ^ (y << 22);
    sh_xor    = y;
    t         = {1'b0, sh_lag_lo} + {1'b0, sh_lag_hi} + {31'b0, sh_carry};
    sh_lag_lo = sh_lag_hi;
    sh_carry  = t[31];
    sh_lag_hi = t[30:0];
    sh_count  = sh_count + WEYL_STEP;
    return sh_count + sh_xor + {1'b0, sh_lag_hi};
  endfunction

  // uniform as a 0.32 fraction plus 2^-23
  function automatic longint unsigned uniform_q32();
    longint unsigned r;
    r = {32'b0, jkiss_next()};
    return r + 64'd512;
  endfunction

  // -4 ln u in Q.56, u in Q.30
  function automatic longint neg_log4(input longint unsigned u30);
    int              k;
    longint unsigned m;
    longint          frac;
    longint          l2;
    k    = 30;
    frac = 0;
    while (k > 0 && u30[k] == 1'b0) k--;
    m = u30 << (30 - k);
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'd1 << 31) begin
        m = m >> 1;
        frac = frac | (64'sd1 <<< i);
      end
    end
    l2 = longint'(k - 30) * (64'sd1 <<< 30) + frac;
    return -l2 * LN2_Q26 * 4;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_gaussian();
    longint unsigned uq, u2, whole, part, mag, xq, u30;
    longint          v, x2, qa, qr, s;
    bit              ok;
    s = 0;
    for (int tries = 0; tries < MAX_TRIES; tries++) begin
      uq    = uniform_q32();
      u2    = uniform_q32();
      whole = u2 >> 32;
      part  = u2 & 64'hffff_ffff;
      v     = longint'(whole * V_SCALE + ((part * V_SCALE) >> 32)) - longint'(V_OFFSET);
      mag   = (v < 0) ? longint'(-v) : longint'(v);
      xq    = (mag << 29) / uq;
      if (xq >= (64'd8 << 28)) continue;
      x2  = longint'(xq * xq);
      u30 = uq >> 2;
      qa  = (64'sd6 <<< 56) - longint'(u30 << 29) + longint'((u30 * u30) >> 3);
      if (x2 <= qa) begin
        ok = 1'b1;
      end else begin
        qr = longint'((64'd1 << 62) / u30) - 4 * longint'(u30);
        if (qr < (64'sd1 <<< 37) && x2 > qr * (64'sd1 <<< 25)) continue;
        ok = (x2 <= neg_log4(u30));
      end
      if (ok) begin
        s = longint'(xq >> 12);
        if (v < 0) s = -s;
        if (s > 524287) s = 524287;
        if (s < -524288) s = -524288;
        break;
      end
    end
    return s[SAMPLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and the receiving side
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold the result channel back about a quarter of the time, never when calm
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 26);
  end

  // Track seed writes and accepted items, check every sample taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SEED_X: sh_count  = cfg_data_i;
          CFG_SEED_Y: sh_xor    = cfg_data_i;
          CFG_SEED_Z: sh_lag_lo = cfg_data_i[30:0];
          CFG_SEED_W: sh_lag_hi = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o && draw_request_i) pending_samples.push_back(next_gaussian());
      if (out_valid_o && out_ready_i) begin
        n_samples++;
        if (pending_samples.size() == 0) begin
          n_errors++;
          $error("sample: unexpected item, actual %0d", sample_o);
        end else begin
          logic signed [SAMPLE_W-1:0] want;
          want = pending_samples.pop_front();
          if (sample_o !== want) begin
            n_errors++;
            $error("sample: expected %0d, actual %0d", want, sample_o);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sending side
  // --------------------------------------------------------------------------
  task automatic send_draw(input bit req);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    draw_request_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (req) n_requests++;
    else n_zero_requests++;
  endtask

  // Drop valid, drain every sample, then let a zero request settle
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    n_seed_writes++;
  endtask

  task automatic add_row(input bit wr, input logic [CFG_INDEX_W-1:0] idx,
                         input logic [31:0] data, input bit req);
    stim_row_t r;
    r.wr = wr; r.idx = idx; r.data = data; r.req = req;
    directed.push_back(r);
  endtask

  initial begin
    bit last_was_write;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    draw_request_i = 1'b0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_SEED_X;
    cfg_data_i     = '0;
    calm           = 1'b0;
    sh_count       = SEED_X_RST;
    sh_xor         = SEED_Y_RST;
    sh_lag_lo      = SEED_Z_RST;
    sh_lag_hi      = SEED_W_RST;
    sh_carry       = 1'b0;

    // Directed table: samples from reset seeds, a zero request, seed extremes,
    // a zero xorshift seed, then back to the reset seeds
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(0, CFG_SEED_X, 0, 0);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(1, CFG_SEED_X, 32'h0000_0000, 0);
    add_row(1, CFG_SEED_Y, 32'hffff_ffff, 0);
    add_row(1, CFG_SEED_Z, 32'h0000_0000, 0);
    add_row(1, CFG_SEED_W, 32'h7fff_ffff, 0);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(1, CFG_SEED_X, 32'hffff_ffff, 0);
    add_row(1, CFG_SEED_Y, 32'h0000_0001, 0);
    add_row(1, CFG_SEED_Z, 32'hffff_ffff, 0);
    add_row(1, CFG_SEED_W, 32'h8000_0000, 0);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(0, CFG_SEED_X, 0, 0);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(1, CFG_SEED_Y, 32'h0000_0000, 0);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(0, CFG_SEED_X, 0, 1);
    add_row(1, CFG_SEED_X, SEED_X_RST, 0);
    add_row(1, CFG_SEED_Y, SEED_Y_RST, 0);
    add_row(1, CFG_SEED_Z, {1'b0, SEED_Z_RST}, 0);
    add_row(1, CFG_SEED_W, {1'b0, SEED_W_RST}, 0);
    add_row(0, CFG_SEED_X, 0, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    last_was_write = 1'b1;
    foreach (directed[i]) begin
      if (directed[i].wr) begin
        // back-to-back writes need no second drain
        if (!last_was_write) wait_quiet();
        write_seed(directed[i].idx, directed[i].data);
      end else begin
        send_draw(directed[i].req);
      end
      last_was_write = directed[i].wr;
    end

    // Random part: eleven phases, each opened by fresh seeds
    for (int phase = 0; phase < 11; phase++) begin
      wait_quiet();
      calm = (phase == 5);
      for (int s = 0; s < 4; s++) begin
        if (phase == 3) write_seed(s[1:0], (s == 1) ? 32'h0000_0001 : 32'h0000_0000);
        else if (phase == 7) write_seed(s[1:0], 32'hffff_ffff);
        else if ($urandom_range(1) || s == phase % 4) begin
          logic [31:0] sd;
          sd = $urandom;
          if (s == 1 && sd == 0) sd = 32'd1;
          write_seed(s[1:0], sd);
        end
      end
      for (int n = 0; n < 100; n++) send_draw($urandom_range(99) >= 5);
    end

    wait_quiet();
    $display("Checked %0d samples from %0d draw requests and %0d zero requests,",
             n_samples, n_requests, n_zero_requests);
    $display("across %0d seed writes including extreme and zero seeds.", n_seed_writes);
    if (n_errors == 0 && pending_samples.size() == 0) begin
      $display("gaussian_sample_generator_core verification clean");
    end else begin
      $display("gaussian_sample_generator_core verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #80_000_000;
    $display("gaussian_sample_generator_core verification failed");
    $finish;
  end

endmodule

FILE: gaussian_sample_generator_core.f
src/gsg_pkg.sv
src/gsg_front.sv
src/gsg_div.sv
src/gsg_back.sv
src/gaussian_sample_generator_core.sv
tb/gaussian_sample_generator_core_tb.sv
